### rtl/core/alid_pkg.sv
package alid_pkg;

   // widest count and position used inside the cell row (covers a capacity of 1024)
   localparam int CNT_W = 11;
   localparam int GROUP_SIZE = 16;
   localparam int DEFAULT_CAPACITY = 128;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_INSERT = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;
   localparam logic [2:0] OP_SEARCH = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_BAD_POS   = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]         operation;
      logic [7:0]         position;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         found_index;
      logic signed [31:0] read_value;
      logic [7:0]         length;
   } rsp_type;

   typedef enum logic [1:0] {
      CM_HOLD,
      CM_APPEND,
      CM_INSERT,
      CM_DELETE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type      mode;
      logic               sample;
      logic [CNT_W-1:0]   pos;
      logic [CNT_W-1:0]   count;
      logic signed [31:0] value;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GROUP,
      S_FINAL
   } state_type;

endpackage

### rtl/core/alid_cell.sv
module alid_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  alid_pkg::cell_ctl_type     ctl,
   input  logic signed [31:0]         left_entry,
   input  logic signed [31:0]         right_entry,
   output logic signed [31:0]         entry,
   output logic                       match,
   output logic                       sel
);
   import alid_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic signed [31:0] entry_ff, entry_in;
   logic               match_ff, match_in;
   logic               sel_ff, sel_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         CM_APPEND: begin
            if (MY_IDX == ctl.count) entry_in = ctl.value;
         end
         CM_INSERT: begin
            if (MY_IDX == ctl.pos) entry_in = ctl.value;
            else if (MY_IDX > ctl.pos) entry_in = left_entry;
         end
         CM_DELETE: begin
            if (MY_IDX >= ctl.pos) entry_in = right_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   // flags look at the contents before this cycle's update
   always_comb begin
      match_in = match_ff;
      sel_in   = sel_ff;
      if (ctl.sample) begin
         match_in = (entry_ff == ctl.value) && (MY_IDX < ctl.count);
         sel_in   = (MY_IDX == ctl.pos);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         match_ff <= match_in;
         sel_ff   <= sel_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;
   assign sel   = sel_ff;

endmodule

### rtl/core/alid_group.sv
module alid_group (
   input  logic                                        clock,
   input  logic                                        match [alid_pkg::GROUP_SIZE],
   input  logic                                        sel   [alid_pkg::GROUP_SIZE],
   input  logic signed [31:0]                          data  [alid_pkg::GROUP_SIZE],
   output logic                                        any_hit,
   output logic [$clog2(alid_pkg::GROUP_SIZE)-1:0]     hit_idx,
   output logic signed [31:0]                          rd_data
);
   import alid_pkg::*;

   localparam int GIW = $clog2(GROUP_SIZE);

   logic               any_ff, any_in;
   logic [GIW-1:0]     idx_ff, idx_in;
   logic signed [31:0] rd_ff, rd_in;

   // lowest matching cell wins
   always_comb begin
      any_in = 1'b0;
      idx_in = '0;
      rd_in  = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (match[i]) begin
            any_in = 1'b1;
            idx_in = GIW'(i);
         end
         rd_in = rd_in | (sel[i] ? data[i] : 32'sd0);
      end
   end

   always_ff @(posedge clock) begin
      any_ff <= any_in;
      idx_ff <= idx_in;
      rd_ff  <= rd_in;
   end

   assign any_hit = any_ff;
   assign hit_idx = idx_ff;
   assign rd_data = rd_ff;

endmodule

### rtl/core/array_list_insert_delete_search.sv
// channel   ports                               direction  contents
// request   req_valid req_ready req_payload     in         operation, position, item_value
// response  rsp_valid rsp_ready rsp_payload     out        status, found_index, read_value, length
//
// each request passes these steps to its response: accept, cell row update and
// compare, per-group reduction of 16 cells, final select into the response register
// so a new request waits until the last leaves final select; the cell row is busy for the whole span
// reset empties the list at once (length zero), entry contents are not cleared
// a stalled response holds the final select until the response register frees;
// the next request is accepted while a response still waits
module array_list_insert_delete_search #(
   parameter int CAPACITY = alid_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  alid_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output alid_pkg::rsp_type rsp_payload
);
   import alid_pkg::*;

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int NG  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NC  = NG * GROUP_SIZE;
   localparam int GIW = $clog2(GROUP_SIZE);
   localparam int FIW = $clog2(NC);
   localparam int FW  = (FIW > 7) ? FIW : 7;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctl_type  ctl;
   logic [CNT_W-1:0] cnt_ext, pos_ext;

   logic signed [31:0] entry_w [NC];
   logic               match_w [NC];
   logic               sel_w   [NC];

   logic               grp_any [NG];
   logic [GIW-1:0]     grp_idx [NG];
   logic signed [31:0] grp_rd  [NG];

   logic               hit;
   logic [FW-1:0]      found;
   logic signed [31:0] rd_all;

   assign cnt_ext = CNT_W'(count_ff);
   assign pos_ext = CNT_W'(req_ff.position);

   genvar gi;
   generate
      for (gi = 0; gi < NC; gi++) begin : g_cell
         if (gi < CAPACITY) begin : g_real
            alid_cell #(.IDX(gi)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .left_entry ((gi == 0) ? 32'sd0 : entry_w[(gi == 0) ? 0 : gi - 1]),
               .right_entry((gi == CAPACITY - 1) ? entry_w[gi]
                                                 : entry_w[(gi == CAPACITY - 1) ? gi : gi + 1]),
               .entry      (entry_w[gi]),
               .match      (match_w[gi]),
               .sel        (sel_w[gi])
            );
         end else begin : g_pad
            assign entry_w[gi] = 32'sd0;
            assign match_w[gi] = 1'b0;
            assign sel_w[gi]   = 1'b0;
         end
      end
      for (gi = 0; gi < NG; gi++) begin : g_grp
         alid_group u_group (
            .clock  (clock),
            .match  (match_w[gi*GROUP_SIZE +: GROUP_SIZE]),
            .sel    (sel_w[gi*GROUP_SIZE +: GROUP_SIZE]),
            .data   (entry_w[gi*GROUP_SIZE +: GROUP_SIZE]),
            .any_hit(grp_any[gi]),
            .hit_idx(grp_idx[gi]),
            .rd_data(grp_rd[gi])
         );
      end
   endgenerate

   // first group with a hit gives the lowest index
   always_comb begin
      hit    = 1'b0;
      found  = '0;
      rd_all = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            hit   = 1'b1;
            found = FW'(g * GROUP_SIZE) + FW'(grp_idx[g]);
         end
         rd_all = rd_all | grp_rd[g];
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ctl.mode     = CM_HOLD;
      ctl.sample   = 1'b0;
      ctl.pos      = pos_ext;
      ctl.count    = cnt_ext;
      ctl.value    = req_ff.item_value;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.sample = 1'b1;
            status_in  = ST_OK;
            case (req_ff.operation)
               OP_CLEAR: count_in = '0;
               OP_APPEND: begin
                  if (cnt_ext >= CAP_C) status_in = ST_FULL;
                  else begin
                     ctl.mode = CM_APPEND;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_READ: begin
                  if (pos_ext >= cnt_ext) status_in = ST_BAD_POS;
               end
               OP_INSERT: begin
                  if (pos_ext > cnt_ext) status_in = ST_BAD_POS;
                  else if (cnt_ext >= CAP_C) status_in = ST_FULL;
                  else begin
                     ctl.mode = CM_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_DELETE: begin
                  if (pos_ext >= cnt_ext) status_in = ST_BAD_POS;
                  else begin
                     ctl.mode = CM_DELETE;
                     count_in = count_ff - CW'(1);
                  end
               end
               default: status_in = ST_OK;
            endcase
            state_in = S_GROUP;
         end
         S_GROUP: state_in = S_FINAL;
         S_FINAL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status      = status_ff;
               rsp_in.found_index = '0;
               rsp_in.read_value  = '0;
               rsp_in.length      = 8'(count_ff);
               if (req_ff.operation == OP_SEARCH) begin
                  if (hit) begin
                     rsp_in.status      = ST_OK;
                     rsp_in.found_index = found[6:0];
                  end else begin
                     rsp_in.status = ST_NOT_FOUND;
                  end
               end
               if (req_ff.operation == OP_READ && status_ff == ST_OK) rsp_in.read_value = rd_all;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(CAPACITY) >= count_ff)
      else $error("list length above capacity");

   a_count_only_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EXEC |=> $stable(count_ff))
      else $error("list length changed outside the update cycle");

   a_final_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("final select did not load the response");

   a_not_found_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_NOT_FOUND |-> rsp_ff.found_index == 7'd0)
      else $error("not-found response carries an index");
`endif

endmodule
